/* rtl/efnf_pkg.sv */
package efnf_pkg;

    localparam int ROWS         = 64;
    localparam int COLS         = 128;
    localparam int FRAME_PIXELS = ROWS * COLS;
    localparam int ADDR_W       = $clog2(FRAME_PIXELS);
    localparam int ROW_W        = $clog2(ROWS);
    localparam int COL_W        = $clog2(COLS);
    localparam int PIX_W        = 8;
    localparam int D_W          = 12;
    localparam int OFF_W        = 12;
    localparam int SCALE_SH     = 8;
    localparam int NUM_W        = OFF_W + SCALE_SH;
    localparam int Q_W          = 9;
    localparam int TAP_W        = 3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [PIX_W-1:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic           result_valid;
        logic [Q_W-1:0] emboss_value;
        logic           last_of_frame;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_FWAIT,
        ST_FDIV,
        ST_SEND
    } state_t;

endpackage

/* rtl/efnf_div.sv */
module efnf_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [efnf_pkg::NUM_W-1:0]   dividend,
    input  logic [efnf_pkg::OFF_W-1:0]   divisor,
    output logic                         done,
    output logic [efnf_pkg::Q_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(efnf_pkg::NUM_W);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [efnf_pkg::OFF_W-1:0]    rem_reg;
    logic [efnf_pkg::NUM_W-1:0]    quo_reg;
    logic [efnf_pkg::OFF_W-1:0]    div_reg;
    logic [efnf_pkg::OFF_W:0]      trial;
    logic                          q_bit;
    logic [efnf_pkg::OFF_W-1:0]    rem_next;

    always_comb
    begin
        trial = {rem_reg, quo_reg[efnf_pkg::NUM_W-1]};
        q_bit = (trial >= {1'b0, div_reg});
        if (q_bit)
        begin
            rem_next = efnf_pkg::OFF_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[efnf_pkg::OFF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(efnf_pkg::NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[efnf_pkg::NUM_W-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[efnf_pkg::Q_W-1:0];

endmodule

/* rtl/emboss_filter_normalize_frame_unit.sv */
// Load: one transfer per cycle while idle; a fetch with no frame ready returns an empty result.
// The last load of a frame starts a filter pass of five taps per position over the
// whole frame, one pixel memory read per tap, during which no input is taken.
// Fetch: a gradient memory read, then a 20-step restoring divider if max > min.
// Reset (rst_n, asynchronous, active low) clears control state, min/max and positions;
// both memories hold undefined data until written.
module emboss_filter_normalize_frame_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  efnf_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output efnf_pkg::out_item_t  out_data
);

    localparam int ADDR_W = efnf_pkg::ADDR_W;
    localparam int D_W    = efnf_pkg::D_W;

    efnf_pkg::state_t state_reg, state_next;

    logic [efnf_pkg::PIX_W-1:0] pixel_mem [efnf_pkg::FRAME_PIXELS];
    logic signed [D_W-1:0]      grad_mem  [efnf_pkg::FRAME_PIXELS];

    logic [ADDR_W-1:0]              load_pos_reg;
    logic [ADDR_W-1:0]              readout_pos_reg;
    logic [ADDR_W-1:0]              pos_reg;
    logic [efnf_pkg::ROW_W-1:0]     row_reg;
    logic [efnf_pkg::COL_W-1:0]     col_reg;
    logic [efnf_pkg::TAP_W-1:0]     tap_reg;
    logic signed [D_W-1:0]          acc_reg;
    logic                           oob_reg;
    logic                           first_reg;
    logic signed [D_W-1:0]          min_reg;
    logic signed [D_W-1:0]          max_reg;
    logic                           frame_ready_reg;
    efnf_pkg::out_item_t            res_reg;
    efnf_pkg::out_item_t            out_reg;
    logic                           out_valid_reg;
    logic [efnf_pkg::PIX_W-1:0]     pix_rdata_reg;
    logic signed [D_W-1:0]          grad_rdata_reg;

    logic                           in_fire;
    logic                           out_free;
    logic                           load_last;
    logic                           col_last;
    logic                           row_last;
    logic                           pos_last;
    logic                           readout_last;
    logic                           pix_we;
    logic                           grad_we;
    logic                           div_start;
    logic                           div_done;
    logic [efnf_pkg::Q_W-1:0]       div_q;
    logic [ADDR_W-1:0]              pix_raddr;
    logic                           oob_next;
    logic [D_W-1:0]                 px_ext;
    logic signed [D_W-1:0]          term;
    logic signed [D_W-1:0]          acc_sum;
    logic [D_W:0]                   span_wide;
    logic [D_W:0]                   off_wide;
    logic [efnf_pkg::OFF_W-1:0]     span;
    logic [efnf_pkg::OFF_W-1:0]     off;

    assign in_ready     = (state_reg == efnf_pkg::ST_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign out_free     = !out_valid_reg || out_ready;
    assign load_last    = (load_pos_reg == ADDR_W'(efnf_pkg::FRAME_PIXELS - 1));
    assign col_last     = (col_reg == efnf_pkg::COL_W'(efnf_pkg::COLS - 1));
    assign row_last     = (row_reg == efnf_pkg::ROW_W'(efnf_pkg::ROWS - 1));
    assign pos_last     = (pos_reg == ADDR_W'(efnf_pkg::FRAME_PIXELS - 1));
    assign readout_last = (readout_pos_reg == ADDR_W'(efnf_pkg::FRAME_PIXELS - 1));

    assign span_wide = {max_reg[D_W-1], max_reg} - {min_reg[D_W-1], min_reg};
    assign off_wide  = {grad_rdata_reg[D_W-1], grad_rdata_reg} - {min_reg[D_W-1], min_reg};
    assign span      = span_wide[efnf_pkg::OFF_W-1:0];
    assign off       = off_wide[efnf_pkg::OFF_W-1:0];

    always_comb
    begin
        case (tap_reg)
            efnf_pkg::TAP_W'(1): pix_raddr = pos_reg + ADDR_W'(1);
            efnf_pkg::TAP_W'(2): pix_raddr = pos_reg + ADDR_W'(efnf_pkg::COLS);
            efnf_pkg::TAP_W'(3): pix_raddr = pos_reg + ADDR_W'(efnf_pkg::COLS + 1);
            default:             pix_raddr = pos_reg;
        endcase
        case (tap_reg)
            efnf_pkg::TAP_W'(1): oob_next = col_last;
            efnf_pkg::TAP_W'(2): oob_next = row_last;
            efnf_pkg::TAP_W'(3): oob_next = col_last || row_last;
            default:             oob_next = 1'b0;
        endcase
        px_ext = oob_reg ? '0 : {{(D_W - efnf_pkg::PIX_W){1'b0}}, pix_rdata_reg};
        if (tap_reg == efnf_pkg::TAP_W'(4))
        begin
            term = signed'((px_ext << 2) + (px_ext << 1));
        end
        else
        begin
            term = -signed'(px_ext << 1);
        end
        acc_sum = acc_reg + term;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            efnf_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_data.operation == efnf_pkg::OP_LOAD)
                    begin
                        if (load_last)
                        begin
                            state_next = efnf_pkg::ST_CALC;
                        end
                    end
                    else if (frame_ready_reg)
                    begin
                        state_next = efnf_pkg::ST_FWAIT;
                    end
                    else
                    begin
                        state_next = efnf_pkg::ST_SEND;
                    end
                end
            end
            efnf_pkg::ST_CALC:
            begin
                if (tap_reg == efnf_pkg::TAP_W'(4) && pos_last)
                begin
                    state_next = efnf_pkg::ST_IDLE;
                end
            end
            efnf_pkg::ST_FWAIT:
            begin
                state_next = (span == '0) ? efnf_pkg::ST_SEND : efnf_pkg::ST_FDIV;
            end
            efnf_pkg::ST_FDIV:
            begin
                if (div_done)
                begin
                    state_next = efnf_pkg::ST_SEND;
                end
            end
            efnf_pkg::ST_SEND:
            begin
                if (out_free)
                begin
                    state_next = efnf_pkg::ST_IDLE;
                end
            end
            default: state_next = efnf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        pix_we    = 1'b0;
        grad_we   = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            efnf_pkg::ST_IDLE:  pix_we    = in_fire && (in_data.operation == efnf_pkg::OP_LOAD);
            efnf_pkg::ST_CALC:  grad_we   = (tap_reg == efnf_pkg::TAP_W'(4));
            efnf_pkg::ST_FWAIT: div_start = (span != '0);
            efnf_pkg::ST_FDIV:  div_start = 1'b0;
            efnf_pkg::ST_SEND:  div_start = 1'b0;
            default:            div_start = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            pixel_mem[load_pos_reg] <= in_data.pixel_value;
        end
        pix_rdata_reg <= pixel_mem[pix_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (grad_we)
        begin
            grad_mem[pos_reg] <= acc_sum;
        end
        grad_rdata_reg <= grad_mem[readout_pos_reg];
    end

    efnf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({off, {efnf_pkg::SCALE_SH{1'b0}}}),
        .divisor  (span),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= efnf_pkg::ST_IDLE;
            load_pos_reg    <= '0;
            readout_pos_reg <= '0;
            pos_reg         <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            tap_reg         <= '0;
            first_reg       <= 1'b0;
            min_reg         <= '0;
            max_reg         <= '0;
            frame_ready_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == efnf_pkg::ST_SEND && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                efnf_pkg::ST_IDLE:
                begin
                    if (pix_we)
                    begin
                        load_pos_reg <= load_last ? '0 : load_pos_reg + 1'b1;
                        if (load_last)
                        begin
                            pos_reg   <= '0;
                            row_reg   <= '0;
                            col_reg   <= '0;
                            tap_reg   <= '0;
                            first_reg <= 1'b1;
                        end
                    end
                end
                efnf_pkg::ST_CALC:
                begin
                    if (tap_reg == efnf_pkg::TAP_W'(4))
                    begin
                        tap_reg   <= '0;
                        first_reg <= 1'b0;
                        if (first_reg || acc_sum < min_reg)
                        begin
                            min_reg <= acc_sum;
                        end
                        if (first_reg || acc_sum > max_reg)
                        begin
                            max_reg <= acc_sum;
                        end
                        pos_reg <= pos_last ? '0 : pos_reg + 1'b1;
                        if (col_last)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + 1'b1;
                        end
                        else
                        begin
                            col_reg <= col_reg + 1'b1;
                        end
                        if (pos_last)
                        begin
                            frame_ready_reg <= 1'b1;
                            readout_pos_reg <= '0;
                        end
                    end
                    else
                    begin
                        tap_reg <= tap_reg + 1'b1;
                    end
                end
                efnf_pkg::ST_FWAIT: first_reg <= first_reg;
                efnf_pkg::ST_FDIV:  first_reg <= first_reg;
                efnf_pkg::ST_SEND:
                begin
                    if (out_free)
                    begin
                        if (res_reg.result_valid)
                        begin
                            readout_pos_reg <= readout_last ? '0 : readout_pos_reg + 1'b1;
                            if (readout_last)
                            begin
                                frame_ready_reg <= 1'b0;
                            end
                        end
                    end
                end
                default: first_reg <= first_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == efnf_pkg::ST_CALC)
        begin
            oob_reg <= oob_next;
            acc_reg <= (tap_reg == '0) ? '0 : acc_sum;
        end
        if (state_reg == efnf_pkg::ST_IDLE)
        begin
            res_reg <= '0;
        end
        else if (state_reg == efnf_pkg::ST_FWAIT)
        begin
            res_reg.result_valid  <= 1'b1;
            res_reg.emboss_value  <= '0;
            res_reg.last_of_frame <= readout_last;
        end
        else if (state_reg == efnf_pkg::ST_FDIV && div_done)
        begin
            res_reg.emboss_value <= div_q;
        end
        if (state_reg == efnf_pkg::ST_SEND && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.emboss_value <= efnf_pkg::Q_W'(256)))
        else $error("emboss value above full scale");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.last_of_frame) |-> out_data.result_valid)
        else $error("last flag on an empty result");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.result_valid) |-> (out_data.emboss_value == '0))
        else $error("empty result carries a value");

    a_calc_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == efnf_pkg::ST_CALC && state_next == efnf_pkg::ST_IDLE)
        |=> (frame_ready_reg && readout_pos_reg == '0))
        else $error("frame pass ended without arming readout");
`endif

endmodule
